### hw/rtl/ttt_pkg.sv
// Shared types and constants for the task timer table.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ttt_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int MAX_RESULTS   = 8;
   localparam int FIRE_CNT_W    = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [1:0] REQ_SCHEDULE   = 2'd0;
   localparam logic [1:0] REQ_REMOVE     = 2'd1;
   localparam logic [1:0] REQ_REMOVE_ALL = 2'd2;
   localparam logic [1:0] REQ_CHECK      = 2'd3;

   // one accepted request, as classified by the front end
   typedef struct packed {
      logic [1:0]  op;
      logic        scan;      // needs a walk over the slots
      logic [31:0] now;
      logic [7:0]  handle;
      logic [31:0] period;
      logic [31:0] delay;
      logic [7:0]  tag;
   } cmd_type;

   // queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // one slot entry as held in the table memory
   typedef struct packed {
      logic [7:0]  handle;
      logic [31:0] period;
      logic [31:0] delay;
      logic [7:0]  tag;
      logic [31:0] last_run;
   } slot_type;

endpackage

`default_nettype wire

### hw/rtl/ttt_front.sv
// Front end: takes request beats, classifies them and hands them to the queue.
// Depends on ttt_pkg.
`default_nettype none

module ttt_front
   import ttt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_now,
   input  wire logic [7:0]  req_handle,
   input  wire logic [31:0] req_period,
   input  wire logic [31:0] req_start_delay,
   input  wire logic [7:0]  req_task_tag,
   input  wire q_stat_type  q_stat,
   output logic             q_push,
   output cmd_type          q_cmd
);

   logic    cmd_vld_ff, cmd_vld_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign busy   = cmd_vld_ff && q_stat.full;
   assign accept = start && !busy;
   assign q_push = cmd_vld_ff && !q_stat.full;
   assign q_cmd  = cmd_ff;

   always_comb begin
      cmd_in        = cmd_ff;
      cmd_vld_in    = cmd_vld_ff;
      if (q_push) begin
         cmd_vld_in = 1'b0;
      end
      if (accept) begin
         cmd_vld_in    = 1'b1;
         cmd_in.op     = req_type;
         cmd_in.scan   = (req_type != REQ_REMOVE_ALL);
         cmd_in.now    = req_now;
         cmd_in.handle = req_handle;
         cmd_in.period = req_period;
         cmd_in.delay  = req_start_delay;
         cmd_in.tag    = req_task_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_vld_ff <= 1'b0;
      end else begin
         cmd_vld_ff <= cmd_vld_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

`default_nettype wire

### hw/rtl/ttt_queue.sv
// Two-entry command queue between front end and back end.
// Depends on ttt_pkg.
`default_nettype none

module ttt_queue
   import ttt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output q_stat_type   stat
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ttt_back.sv
// Back end: slot table memory, busy bits and the slot walk that carries out
// each command, plus the registered result beat. Depends on ttt_pkg.
`default_nettype none

module ttt_back
   import ttt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_stat_type q_stat,
   input  wire cmd_type    head_cmd,
   output logic            q_pop,
   output logic            rsp_valid,
   output logic [1:0]      rsp_kind,
   output logic            rsp_fired,
   output logic [7:0]      rsp_fired_handle,
   output logic [7:0]      rsp_fired_tag,
   output logic [2:0]      rsp_slot_index,
   output logic            rsp_ok,
   output logic            rsp_last
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]            state_ff, state_in;
   cmd_type               cur_ff, cur_in;
   logic [IDX_W-1:0]      iss_idx_ff, iss_idx_in;
   logic [NUM_SLOTS-1:0]  busy_ff, busy_in;

   // table memory, one read and one write port
   slot_type              mem [NUM_SLOTS];
   slot_type              rd_data_ff;
   logic                  rd_en;
   logic                  rd_vld_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  wr_en;
   slot_type              wr_data;

   // compare stage
   logic                  s2_vld_ff;
   logic [IDX_W-1:0]      s2_idx_ff;
   slot_type              s2_ent_ff;
   logic [31:0]           s2_elapsed_ff;
   logic [31:0]           s2_next_run_ff;

   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      found_idx_ff, found_idx_in;
   logic [FIRE_CNT_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [7:0]            pend_handle_ff, pend_handle_in;
   logic [7:0]            pend_tag_ff, pend_tag_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;

   logic                  s2_busy, due, fire;
   logic                  emit;
   logic [1:0]            emit_kind;
   logic                  emit_fired, emit_ok, emit_last;
   logic [7:0]            emit_handle, emit_tag;
   logic [IDX_W-1:0]      emit_idx;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_kind_ff;
   logic                  rsp_fired_ff, rsp_ok_ff, rsp_last_ff;
   logic [7:0]            rsp_handle_ff, rsp_tag_ff;
   logic [2:0]            rsp_idx_ff;

   assign q_pop  = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rd_en  = (state_ff == ST_SCAN);
   assign s2_busy = busy_ff[s2_idx_ff];
   assign due    = s2_busy && (s2_elapsed_ff >= s2_ent_ff.delay) &&
                   ((s2_ent_ff.period == '0) || (s2_elapsed_ff >= s2_ent_ff.period));
   assign fire   = s2_vld_ff && (cur_ff.op == REQ_CHECK) && due &&
                   (fire_cnt_ff < FIRE_CNT_W'(MAX_RESULTS));

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      iss_idx_in     = iss_idx_ff;
      busy_in        = busy_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      fire_cnt_in    = fire_cnt_ff;
      pend_vld_in    = pend_vld_ff;
      pend_handle_in = pend_handle_ff;
      pend_tag_in    = pend_tag_ff;
      pend_idx_in    = pend_idx_ff;
      wr_en          = 1'b0;
      wr_data        = s2_ent_ff;
      emit           = 1'b0;
      emit_kind      = cur_ff.op;
      emit_fired     = 1'b0;
      emit_handle    = '0;
      emit_tag       = '0;
      emit_idx       = '0;
      emit_ok        = 1'b0;
      emit_last      = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               cur_in      = head_cmd;
               iss_idx_in  = '0;
               found_in    = 1'b0;
               fire_cnt_in = '0;
               pend_vld_in = 1'b0;
               if (head_cmd.scan) begin
                  state_in = ST_SCAN;
               end else begin
                  busy_in   = '0;
                  emit      = 1'b1;
                  emit_kind = REQ_REMOVE_ALL;
               end
            end
         end
         ST_SCAN: begin
            iss_idx_in = iss_idx_ff + 1'b1;
            if (iss_idx_ff == IDX_W'(NUM_SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !s2_vld_ff) begin
               state_in = ST_IDLE;
               emit     = 1'b1;
               if (cur_ff.op == REQ_CHECK) begin
                  if (pend_vld_ff) begin
                     emit_fired  = 1'b1;
                     emit_handle = pend_handle_ff;
                     emit_tag    = pend_tag_ff;
                     emit_idx    = pend_idx_ff;
                     emit_ok     = 1'b1;
                  end
               end else if (found_ff) begin
                  emit_idx = found_idx_ff;
                  emit_ok  = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // compare stage: one slot per cycle
      if (s2_vld_ff) begin
         case (cur_ff.op)
            REQ_SCHEDULE: begin
               if (!s2_busy && !found_ff) begin
                  found_in            = 1'b1;
                  found_idx_in        = s2_idx_ff;
                  busy_in[s2_idx_ff]  = 1'b1;
                  wr_en               = 1'b1;
                  wr_data.handle      = cur_ff.handle;
                  wr_data.period      = cur_ff.period;
                  wr_data.delay       = cur_ff.delay;
                  wr_data.tag         = cur_ff.tag;
                  wr_data.last_run    = cur_ff.now;
               end
            end
            REQ_REMOVE: begin
               if (s2_busy && !found_ff && (s2_ent_ff.handle == cur_ff.handle)) begin
                  found_in           = 1'b1;
                  found_idx_in       = s2_idx_ff;
                  busy_in[s2_idx_ff] = 1'b0;
               end
            end
            REQ_CHECK: begin
               if (fire) begin
                  fire_cnt_in = fire_cnt_ff + 1'b1;
                  if (s2_ent_ff.period != '0) begin
                     wr_en            = 1'b1;
                     wr_data.last_run = s2_next_run_ff;
                  end else begin
                     busy_in[s2_idx_ff] = 1'b0;
                  end
                  // a held firing goes out once another one is known to follow
                  if (pend_vld_ff) begin
                     emit        = 1'b1;
                     emit_fired  = 1'b1;
                     emit_handle = pend_handle_ff;
                     emit_tag    = pend_tag_ff;
                     emit_idx    = pend_idx_ff;
                     emit_ok     = 1'b1;
                     emit_last   = 1'b0;
                  end
                  pend_vld_in    = 1'b1;
                  pend_handle_in = s2_ent_ff.handle;
                  pend_tag_in    = s2_ent_ff.tag;
                  pend_idx_in    = s2_idx_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         fire_cnt_ff  <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rd_vld_ff    <= rd_en;
         s2_vld_ff    <= rd_vld_ff;
         found_ff     <= found_in;
         fire_cnt_ff  <= fire_cnt_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= emit;
      end
      cur_ff         <= cur_in;
      iss_idx_ff     <= iss_idx_in;
      found_idx_ff   <= found_idx_in;
      pend_handle_ff <= pend_handle_in;
      pend_tag_ff    <= pend_tag_in;
      pend_idx_ff    <= pend_idx_in;
      rd_idx_ff      <= iss_idx_ff;
      s2_idx_ff      <= rd_idx_ff;
      s2_ent_ff      <= rd_data_ff;
      s2_elapsed_ff  <= cur_ff.now - rd_data_ff.last_run;
      s2_next_run_ff <= rd_data_ff.last_run + rd_data_ff.period;
      rsp_kind_ff    <= emit_kind;
      rsp_fired_ff   <= emit_fired;
      rsp_handle_ff  <= emit_handle;
      rsp_tag_ff     <= emit_tag;
      rsp_idx_ff     <= 3'(emit_idx);
      rsp_ok_ff      <= emit_ok;
      rsp_last_ff    <= emit_last;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s2_idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[iss_idx_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_fired_handle = rsp_handle_ff;
   assign rsp_fired_tag    = rsp_tag_ff;
   assign rsp_slot_index   = rsp_idx_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_walk_owns_pipe: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff || rd_vld_ff) |-> (state_ff != ST_IDLE))
      else $error("slot pipeline active while back end idle");

   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= FIRE_CNT_W'(MAX_RESULTS))
      else $error("more firings than one check may report");

   a_fired_is_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fired_ff) |-> (rsp_kind_ff == REQ_CHECK) && rsp_ok_ff)
      else $error("firing reported outside a check");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      (q_pop && head_cmd.scan) |=> (state_ff == ST_SCAN) && (iss_idx_ff == '0))
      else $error("walk did not start at slot zero");
`endif

endmodule

`default_nettype wire

### hw/rtl/task_timer_table_top.sv
// Top level of the task timer table: front end, command queue, back end.
// Depends on ttt_pkg, ttt_front, ttt_queue and ttt_back.
//
//   channel   strobe / hold     ports                         beat taken when
//   request   start / busy      req_type .. req_task_tag      start && !busy
//   result    rsp_valid         rsp_kind .. rsp_last          rsp_valid (one cycle)
//
// A remove-all clears every busy bit in the back end without a walk. Schedule,
// remove and check walk every slot once through the table memory's single read
// port, one slot a cycle; the back end pops the next request only when idle.
// Reset (synchronous) frees every slot and empties the queue.
// Up to three requests wait in the front register and the queue; busy rises
// when they are full. Results cannot be stalled.
`default_nettype none

module task_timer_table_top
   import ttt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_now,
   input  wire logic [7:0]  req_handle,
   input  wire logic [31:0] req_period,
   input  wire logic [31:0] req_start_delay,
   input  wire logic [7:0]  req_task_tag,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic             rsp_fired,
   output logic [7:0]       rsp_fired_handle,
   output logic [7:0]       rsp_fired_tag,
   output logic [2:0]       rsp_slot_index,
   output logic             rsp_ok,
   output logic             rsp_last
);

   q_stat_type q_stat;
   logic       q_push, q_pop;
   cmd_type    push_cmd, head_cmd;

   ttt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_now         (req_now),
      .req_handle      (req_handle),
      .req_period      (req_period),
      .req_start_delay (req_start_delay),
      .req_task_tag    (req_task_tag),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   ttt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   ttt_back #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .head_cmd         (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_fired        (rsp_fired),
      .rsp_fired_handle (rsp_fired_handle),
      .rsp_fired_tag    (rsp_fired_tag),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_ok           (rsp_ok),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
